// ===== rtl/pafd_pkg.sv =====
// Shared types, constants and character tables for the packed field decoder.
// Used by pafd_ctrl, pafd_dpath and packed_alphanumeric_field_decoder.
package pafd_pkg;

	localparam int MAX_VALUE_BITS = 64;
	localparam int DEC_DIGITS = (MAX_VALUE_BITS * 30103) / 100000 + 1;
	localparam int DIG_W = $clog2(DEC_DIGITS);
	localparam int DCNT_W = $clog2(DEC_DIGITS + 1);
	localparam int CONV_W = $clog2(MAX_VALUE_BITS + 1);
	localparam int NUM_ZERO_N = (100 * MAX_VALUE_BITS + 1 + 331) / 332;

	localparam logic [31:0] DIV40_MUL = 32'd52429;
	localparam int DIV40_SH = 21;
	localparam logic [19:0] DIV3_MUL = 20'd683;
	localparam int DIV3_SH = 11;

	localparam logic [2:0] LEN_RESET = 3'd5;

	localparam logic [2:0] ENC_NUM = 3'd0;
	localparam logic [2:0] ENC_HEXU = 3'd1;
	localparam logic [2:0] ENC_HEXL = 3'd2;
	localparam logic [2:0] ENC_B64 = 3'd3;
	localparam logic [2:0] ENC_ASCII = 3'd4;
	localparam logic [2:0] ENC_B40 = 3'd5;
	localparam logic [2:0] ENC_FIRST_BAD = 3'd6;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_ENC = 2'd1;
	localparam logic [1:0] ERR_B40 = 2'd2;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_EMIT,
		EV_NUM,
		EV_B40
	} ev_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEAD,
		PH_BODY
	} phase_t;

	typedef struct packed {
		logic load;
		logic step;
		logic conv_step;
		logic num_set;
		logic num_emit;
		logic div1;
		logic div2;
		logic div3;
		logic b40_emit;
	} cmd_t;

	typedef struct packed {
		logic more;
		ev_t  ev;
		logic out_free;
		logic conv_last;
		logic num_more;
		logic b40_more;
	} stat_t;

	function automatic logic [6:0] b64_char(input logic [5:0] i);
		if (i < 6'd26) begin
			return 7'h41 + {1'b0, i};
		end else if (i < 6'd52) begin
			return 7'h61 + {1'b0, i - 6'd26};
		end else if (i < 6'd62) begin
			return 7'h30 + {1'b0, i - 6'd52};
		end else if (i == 6'd62) begin
			return 7'h2b;
		end else begin
			return 7'h5f;
		end
	endfunction

	function automatic logic [6:0] b40_char(input logic [5:0] i);
		if (i < 6'd26) begin
			return 7'h41 + {1'b0, i};
		end else if (i == 6'd26) begin
			return 7'h2d;
		end else if (i == 6'd27) begin
			return 7'h2e;
		end else if (i == 6'd28) begin
			return 7'h3a;
		end else if (i < 6'd39) begin
			return 7'h30 + {1'b0, i - 6'd29};
		end else begin
			return 7'h00;
		end
	endfunction

	function automatic logic [6:0] hex_char(input logic [3:0] s, input logic lower);
		if (s < 4'd10) begin
			return 7'h30 + {3'b0, s};
		end else if (lower) begin
			return 7'h61 + {3'b0, s - 4'd10};
		end else begin
			return 7'h41 + {3'b0, s - 4'd10};
		end
	endfunction

endpackage

// ===== rtl/pafd_ctrl.sv =====
// Controller state machine: sequences byte intake, per-bit steps, decimal
// conversion, base-40 splitting and result emission. Uses pafd_pkg.
module pafd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  pafd_pkg::stat_t st,
	output pafd_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BIT,
		S_CONV,
		S_NUMSET,
		S_NUMOUT,
		S_DIV1,
		S_DIV2,
		S_DIV3,
		S_B40OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d = S_BIT;
				end
			end
			S_BIT: begin
				if (!st.more) begin
					state_d = S_IDLE;
				end else if (st.ev != pafd_pkg::EV_EMIT || st.out_free) begin
					cmd.step = 1'b1;
					if (st.ev == pafd_pkg::EV_NUM) begin
						state_d = S_CONV;
					end else if (st.ev == pafd_pkg::EV_B40) begin
						state_d = S_DIV1;
					end
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (st.conv_last) begin
					state_d = S_NUMSET;
				end
			end
			S_NUMSET: begin
				cmd.num_set = 1'b1;
				state_d = S_NUMOUT;
			end
			S_NUMOUT: begin
				if (!st.num_more) begin
					state_d = S_BIT;
				end else if (st.out_free) begin
					cmd.num_emit = 1'b1;
				end
			end
			S_DIV1: begin
				cmd.div1 = 1'b1;
				state_d = S_DIV2;
			end
			S_DIV2: begin
				cmd.div2 = 1'b1;
				state_d = S_DIV3;
			end
			S_DIV3: begin
				cmd.div3 = 1'b1;
				state_d = S_B40OUT;
			end
			S_B40OUT: begin
				if (!st.b40_more) begin
					state_d = S_BIT;
				end else if (st.out_free) begin
					cmd.b40_emit = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready = (state_q == S_IDLE);

endmodule

// ===== rtl/pafd_dpath.sv =====
// Datapath: bit buffer, field header and body decode, decimal conversion,
// base-40 split and the result register. Uses pafd_pkg.
module pafd_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  pafd_pkg::cmd_t  cmd,
	output pafd_pkg::stat_t st,
	input  logic [2:0]      cfg_len,
	input  logic [7:0]      data_byte,
	input  logic            field_start,
	input  logic [2:0]      skip_bits,
	output logic            result_valid,
	input  logic            result_ready,
	output logic [6:0]      char_code,
	output logic            char_valid,
	output logic            field_last,
	output logic [1:0]      error_code,
	output logic [8:0]      bits_used
);

	localparam int VB = pafd_pkg::MAX_VALUE_BITS;
	localparam int DD = pafd_pkg::DEC_DIGITS;

	logic [7:0]      byte_q;
	logic [3:0]      pos_q;
	pafd_pkg::phase_t phase_q;
	logic [VB-1:0]   buf_q;
	logic [6:0]      held_q;
	logic [8:0]      cons_q;
	logic [2:0]      enc_q;
	logic [5:0]      tgt_q;
	logic [5:0]      done_q;
	logic [VB-1:0]   sh_q;
	logic [3:0]      bcd_q [DD];
	logic [pafd_pkg::CONV_W-1:0] cnt_q;
	logic [5:0]      p_q;
	logic [15:0]     v_q;
	logic [10:0]     q_q;
	logic [5:0]      i0_q;
	logic [5:0]      i1_q;
	logic [5:0]      i2_q;
	logic [1:0]      k_q;

	logic            out_valid_q;
	logic [6:0]      code_q;
	logic            cval_q;
	logic            last_q;
	logic [1:0]      err_q;
	logic [8:0]      used_q;

	logic [2:0]      lb;
	logic [3:0]      hl;
	logic            bitv;
	logic [VB-1:0]   nbuf;
	logic [6:0]      nheld;
	logic [8:0]      ncons;
	logic [2:0]      h_enc;
	logic [5:0]      h_tgt;
	logic            h_hit;
	logic            h_stop;
	logic [9:0]      diff;
	logic            num_hit;
	logic [6:0]      sym_w;
	logic            sym_hit;
	logic [6:0]      sym_code;
	logic [5:0]      ndone;
	logic            sym_last;
	logic [15:0]     word;
	logic            word_bad;
	logic            clr_buf;
	pafd_pkg::ev_t   ev;
	logic [6:0]      ev_code;
	logic            ev_cval;
	logic            ev_last;
	logic [1:0]      ev_err;
	logic [8:0]      ev_used;
	logic [3:0]      adj [DD];
	logic [pafd_pkg::DCNT_W-1:0] dcnt;
	logic [5:0]      pmax;
	logic [3:0]      dsel;
	logic [5:0]      b40_idx;
	logic [8:0]      b40_used;
	logic [19:0]     div3_prod;
	logic            load_out;

	always_comb begin
		lb = (cfg_len == 3'd0) ? 3'd1 : ((cfg_len == 3'd7) ? 3'd6 : cfg_len);
		hl = 4'd3 + {1'b0, lb};
		bitv = byte_q[3'd7 - pos_q[2:0]];
		nbuf = {buf_q[VB-2:0], bitv};
		nheld = held_q + 7'd1;
		ncons = cons_q + 9'd1;
		h_enc = 3'(nbuf[8:0] >> lb);
		h_tgt = nbuf[5:0] & ~(6'h3f << lb);
		h_hit = (nheld >= {3'b0, hl});
		h_stop = (h_enc >= pafd_pkg::ENC_FIRST_BAD) || (h_tgt == 6'd0);
		diff = {1'b0, ncons} - {6'b0, hl};
		num_hit = !diff[9] && ((16'(diff[8:0]) * 16'd100) >= (16'(tgt_q) * 16'd332));
		case (enc_q)
			pafd_pkg::ENC_B64: sym_w = 7'd6;
			pafd_pkg::ENC_ASCII: sym_w = 7'd7;
			default: sym_w = 7'd4;
		endcase
		sym_hit = (nheld >= sym_w);
		case (enc_q)
			pafd_pkg::ENC_B64: sym_code = pafd_pkg::b64_char(nbuf[5:0]);
			pafd_pkg::ENC_ASCII: sym_code = nbuf[6:0];
			default: sym_code = pafd_pkg::hex_char(nbuf[3:0], enc_q == pafd_pkg::ENC_HEXL);
		endcase
		ndone = done_q + 6'd1;
		sym_last = (ndone >= tgt_q);
		word = nbuf[15:0];
		word_bad = (word == 16'd0) || (word > 16'd64000);
		clr_buf = (phase_q == pafd_pkg::PH_HEAD) ? h_hit :
			((phase_q == pafd_pkg::PH_BODY) &&
			((enc_q == pafd_pkg::ENC_B40) ? (nheld >= 7'd16) :
			((enc_q != pafd_pkg::ENC_NUM) && sym_hit)));

		ev = pafd_pkg::EV_NONE;
		ev_code = 7'd0;
		ev_cval = 1'b0;
		ev_last = 1'b1;
		ev_err = pafd_pkg::ERR_NONE;
		ev_used = ncons;
		case (phase_q)
			pafd_pkg::PH_HEAD: begin
				if (h_hit && h_stop) begin
					ev = pafd_pkg::EV_EMIT;
					if (h_enc >= pafd_pkg::ENC_FIRST_BAD) begin
						ev_err = pafd_pkg::ERR_ENC;
					end
				end
			end
			pafd_pkg::PH_BODY: begin
				case (enc_q)
					pafd_pkg::ENC_NUM: begin
						if (num_hit) begin
							ev = pafd_pkg::EV_NUM;
						end
					end
					pafd_pkg::ENC_B40: begin
						if (nheld >= 7'd16) begin
							if (word_bad) begin
								ev = pafd_pkg::EV_EMIT;
								ev_err = pafd_pkg::ERR_B40;
							end else begin
								ev = pafd_pkg::EV_B40;
							end
						end
					end
					default: begin
						if (sym_hit) begin
							ev = pafd_pkg::EV_EMIT;
							ev_code = sym_code;
							ev_cval = 1'b1;
							ev_last = sym_last;
							ev_used = sym_last ? ncons : 9'd0;
						end
					end
				endcase
			end
			default: begin
				ev = pafd_pkg::EV_NONE;
			end
		endcase

		for (int i = 0; i < DD; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		dcnt = pafd_pkg::DCNT_W'(1);
		for (int i = 1; i < DD; i++) begin
			if (bcd_q[i] != 4'd0) begin
				dcnt = pafd_pkg::DCNT_W'(i + 1);
			end
		end
		pmax = (6'(dcnt) > tgt_q) ? 6'(dcnt) : tgt_q;
		dsel = (p_q < 6'(DD)) ? bcd_q[p_q[pafd_pkg::DIG_W-1:0]] : 4'd0;

		case (k_q)
			2'd0: b40_idx = i0_q;
			2'd1: b40_idx = i1_q;
			default: b40_idx = i2_q;
		endcase
		div3_prod = {6'b0, tgt_q, 4'b0} * pafd_pkg::DIV3_MUL;
		b40_used = 9'(div3_prod >> pafd_pkg::DIV3_SH) + {5'b0, hl};

		load_out = (cmd.step && ev == pafd_pkg::EV_EMIT) || cmd.num_emit || cmd.b40_emit;

		st.more = !pos_q[3] && (phase_q != pafd_pkg::PH_IDLE);
		st.ev = ev;
		st.out_free = !out_valid_q || result_ready;
		st.conv_last = (cnt_q == pafd_pkg::CONV_W'(VB - 1));
		st.num_more = (done_q < tgt_q);
		st.b40_more = (k_q != 2'd3) && (done_q < tgt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			pos_q <= 4'd8;
			phase_q <= pafd_pkg::PH_IDLE;
			buf_q <= '0;
			held_q <= '0;
			cons_q <= '0;
			enc_q <= '0;
			tgt_q <= '0;
			done_q <= '0;
			sh_q <= '0;
			for (int i = 0; i < DD; i++) begin
				bcd_q[i] <= 4'd0;
			end
			cnt_q <= '0;
			p_q <= '0;
			v_q <= '0;
			q_q <= '0;
			i0_q <= '0;
			i1_q <= '0;
			i2_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.load) begin
				byte_q <= data_byte;
				if (field_start) begin
					pos_q <= {1'b0, skip_bits};
					phase_q <= pafd_pkg::PH_HEAD;
					buf_q <= '0;
					held_q <= '0;
					cons_q <= '0;
					enc_q <= '0;
					tgt_q <= '0;
					done_q <= '0;
				end else begin
					pos_q <= 4'd0;
				end
			end
			if (cmd.step) begin
				pos_q <= pos_q + 4'd1;
				buf_q <= clr_buf ? '0 : nbuf;
				held_q <= clr_buf ? 7'd0 : nheld;
				cons_q <= ncons;
				case (phase_q)
					pafd_pkg::PH_HEAD: begin
						if (h_hit) begin
							enc_q <= h_enc;
							tgt_q <= h_tgt;
							phase_q <= h_stop ? pafd_pkg::PH_IDLE : pafd_pkg::PH_BODY;
						end
					end
					pafd_pkg::PH_BODY: begin
						case (enc_q)
							pafd_pkg::ENC_NUM: begin
								if (num_hit) begin
									phase_q <= pafd_pkg::PH_IDLE;
									sh_q <= (tgt_q >= 6'(pafd_pkg::NUM_ZERO_N)) ? '0 : nbuf;
									for (int i = 0; i < DD; i++) begin
										bcd_q[i] <= 4'd0;
									end
									cnt_q <= '0;
								end
							end
							pafd_pkg::ENC_B40: begin
								if (nheld >= 7'd16) begin
									k_q <= 2'd0;
									v_q <= word - 16'd1;
									if (word_bad) begin
										phase_q <= pafd_pkg::PH_IDLE;
									end
								end
							end
							default: begin
								if (sym_hit) begin
									done_q <= ndone;
									if (sym_last) begin
										phase_q <= pafd_pkg::PH_IDLE;
									end
								end
							end
						endcase
					end
					default: begin
						phase_q <= pafd_pkg::PH_IDLE;
					end
				endcase
			end
			if (cmd.conv_step) begin
				bcd_q[0] <= {adj[0][2:0], sh_q[VB-1]};
				for (int i = 1; i < DD; i++) begin
					bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
				end
				sh_q <= {sh_q[VB-2:0], 1'b0};
				cnt_q <= cnt_q + pafd_pkg::CONV_W'(1);
			end
			if (cmd.num_set) begin
				p_q <= pmax - 6'd1;
			end
			if (cmd.num_emit) begin
				p_q <= p_q - 6'd1;
				done_q <= ndone;
			end
			if (cmd.div1) begin
				q_q <= 11'((32'(v_q) * pafd_pkg::DIV40_MUL) >> pafd_pkg::DIV40_SH);
			end
			if (cmd.div2) begin
				i0_q <= 6'((32'(q_q) * pafd_pkg::DIV40_MUL) >> pafd_pkg::DIV40_SH);
				i2_q <= 6'(v_q - (16'(q_q) * 16'd40));
			end
			if (cmd.div3) begin
				i1_q <= 6'(q_q - (11'(i0_q) * 11'd40));
			end
			if (cmd.b40_emit) begin
				k_q <= k_q + 2'd1;
				done_q <= ndone;
				if (sym_last) begin
					phase_q <= pafd_pkg::PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && ev == pafd_pkg::EV_EMIT) begin
			code_q <= ev_code;
			cval_q <= ev_cval;
			last_q <= ev_last;
			err_q <= ev_err;
			used_q <= ev_used;
		end else if (cmd.num_emit) begin
			code_q <= 7'h30 + {3'b0, dsel};
			cval_q <= 1'b1;
			last_q <= sym_last;
			err_q <= pafd_pkg::ERR_NONE;
			used_q <= sym_last ? cons_q : 9'd0;
		end else if (cmd.b40_emit) begin
			code_q <= pafd_pkg::b40_char(b40_idx);
			cval_q <= 1'b1;
			last_q <= sym_last;
			err_q <= pafd_pkg::ERR_NONE;
			used_q <= sym_last ? b40_used : 9'd0;
		end
	end

	assign result_valid = out_valid_q;
	assign char_code = code_q;
	assign char_valid = cval_q;
	assign field_last = last_q;
	assign error_code = err_q;
	assign bits_used = used_q;

endmodule

// ===== rtl/packed_alphanumeric_field_decoder.sv =====
// Top level of the packed alphanumeric field decoder: configuration register,
// controller and datapath. Depends on pafd_pkg, pafd_ctrl and pafd_dpath.
//
// Input channel (item_valid/item_ready) takes one stream byte per transaction
// with field_start and skip_bits; output channel (result_valid/result_ready)
// gives one decoded character or closing item per transaction.
// A byte is taken, then one bit is decoded per cycle unless a result waits on
// a busy output or a numeric or base-40 step runs; a closing step returns to
// idle before the next byte is taken (skip_bits counts only on a start byte).
// A character result leaves the result register in the cycle after the bit
// that completes it. A numeric field runs the decimal conversion loop and a
// set-up step, then emits one digit per cycle while the result register is
// free; a base-40 word is split by reciprocal multiplies and emitted likewise.
// The result register frees the decoder: it keeps working while a result
// waits, and stalls only on the next result when the receiver holds ready
// low. Reset clears the decoder state, closes any open field and sets
// length_bits to 5. The APB port writes length_bits at any address with no
// wait states; write it only while no byte is being decoded.
module packed_alphanumeric_field_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        field_start,
	input  logic [2:0]  skip_bits,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [6:0]  char_code,
	output logic        char_valid,
	output logic        field_last,
	output logic [1:0]  error_code,
	output logic [8:0]  bits_used
);

	logic [2:0]      len_q;
	pafd_pkg::cmd_t  cmd;
	pafd_pkg::stat_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= pafd_pkg::LEN_RESET;
		end else if (psel && penable && pwrite) begin
			len_q <= pwdata[2:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {29'b0, len_q} : 32'd0;

	pafd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	pafd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_len      (len_q),
		.data_byte    (data_byte),
		.field_start  (field_start),
		.skip_bits    (skip_bits),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.char_code    (char_code),
		.char_valid   (char_valid),
		.field_last   (field_last),
		.error_code   (error_code),
		.bits_used    (bits_used)
	);

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && st.ev == pafd_pkg::EV_EMIT) || cmd.num_emit || cmd.b40_emit
		|-> (!result_valid || result_ready))
		else $error("result register overwritten while held");

	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !field_last) |-> (char_valid && bits_used == 9'd0))
		else $error("non-final result malformed");

	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && error_code != pafd_pkg::ERR_NONE)
		|-> (field_last && !char_valid && char_code == 7'd0))
		else $error("error item does not close the field");

	a_last_used: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && field_last) |-> (bits_used != 9'd0))
		else $error("closing item without bit count");
`endif

endmodule
